/* rtl/ics_pkg.sv */
// Shared types, constants and step functions for the collision scatter pipeline.
package ics_pkg;

  localparam int VEL_W      = 32;
  localparam int MASS_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int SPEED_W    = 31;
  localparam int CQ_W       = 31;

  localparam logic [1:0] ACT_COLLIDE = 2'd0;
  localparam logic [1:0] ACT_DERIVE  = 2'd1;
  localparam logic [1:0] ACT_REACT   = 2'd2;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [MASS_W-1:0] MASS_RESET = 16'd256;

  // Square root: 66-bit radicand, one root bit per step.
  localparam int SQ_RAD_W  = 66;
  localparam int SQ_ROOT_W = 33;
  localparam int SQ_REM_W  = SQ_ROOT_W + 3;
  localparam int SQ_STEPS  = SQ_ROOT_W;

  localparam int CORDIC_STEPS = 30;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
    32'sd21354465, 32'sd10679838, 32'sd5340245, 32'sd2670163, 32'sd1335087,
    32'sd667544, 32'sd333772, 32'sd166886, 32'sd83443, 32'sd41722,
    32'sd20861, 32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
    32'sd652, 32'sd326, 32'sd163, 32'sd81, 32'sd41,
    32'sd20, 32'sd10, 32'sd5, 32'sd3, 32'sd1
  };

  // Divider: magnitudes up to 50 bits over a 17-bit mass sum.
  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = MASS_W + 1;
  localparam int DIV_LANES = 9;

  typedef logic [2:0][VEL_W-1:0] vec3_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [MASS_W-1:0] mp;
    logic [MASS_W-1:0] mq;
    vec3_t             up;
    vec3_t             uq;
    logic [SPEED_W-1:0] crg;
    logic [CQ_W-1:0]   c30;
  } side_t;

  typedef struct packed {
    logic [SQ_RAD_W-1:0]  rad;
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cordic_t;

  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t n;
    logic [SQ_REM_W-1:0] trial;
    logic [SQ_REM_W-1:0] t;
    trial = {s.rem[SQ_REM_W-3:0], s.rad[SQ_RAD_W-1 -: 2]};
    t = {1'b0, s.root, 2'b01};
    n.rad = {s.rad[SQ_RAD_W-3:0], 2'b00};
    if (trial >= t) begin
      n.rem  = trial - t;
      n.root = {s.root[SQ_ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = trial;
      n.root = {s.root[SQ_ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  function automatic cordic_t cordic_step(cordic_t c, int i);
    cordic_t n;
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    if (c.z >= 0) begin
      n.x = c.x - ys;
      n.y = c.y + xs;
      n.z = c.z - ATAN_TURN[i];
    end else begin
      n.x = c.x + ys;
      n.y = c.y - xs;
      n.z = c.z + ATAN_TURN[i];
    end
    return n;
  endfunction

endpackage

/* rtl/ics_if.sv */
// Handshake interfaces for the particle pair item and the scatter result item.
interface ics_pair_if import ics_pkg::*; #(parameter int RAND_BITS = 24);
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [1:0]              species_p;
  logic [1:0]              species_q;
  logic signed [VEL_W-1:0] up_x;
  logic signed [VEL_W-1:0] up_y;
  logic signed [VEL_W-1:0] up_z;
  logic signed [VEL_W-1:0] uq_x;
  logic signed [VEL_W-1:0] uq_y;
  logic signed [VEL_W-1:0] uq_z;
  logic [SPEED_W-1:0]      rel_speed;
  logic [RAND_BITS-1:0]    rand_theta;
  logic [RAND_BITS-1:0]    rand_phi;

  modport source (output valid, action, species_p, species_q, up_x, up_y, up_z,
                  uq_x, uq_y, uq_z, rel_speed, rand_theta, rand_phi, input ready);
  modport sink (input valid, action, species_p, species_q, up_x, up_y, up_z,
                uq_x, uq_y, uq_z, rel_speed, rand_theta, rand_phi, output ready);
endinterface

interface ics_scatter_if import ics_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] new_up_x;
  logic signed [VEL_W-1:0] new_up_y;
  logic signed [VEL_W-1:0] new_up_z;
  logic signed [VEL_W-1:0] new_uq_x;
  logic signed [VEL_W-1:0] new_uq_y;
  logic signed [VEL_W-1:0] new_uq_z;
  logic                    saturated;

  modport source (output valid, new_up_x, new_up_y, new_up_z, new_uq_x, new_uq_y,
                  new_uq_z, saturated, input ready);
  modport sink (input valid, new_up_x, new_up_y, new_up_z, new_uq_x, new_uq_y,
                new_uq_z, saturated, output ready);
endinterface

/* rtl/ics_div.sv */
// Pipelined restoring divider: several magnitude lanes over one shared divisor.
module ics_div import ics_pkg::*; #(
  parameter int LANES = 9,
  parameter int NUM_W = 50,
  parameter int DEN_W = 17
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [LANES-1:0][NUM_W-1:0] num,
  input  logic [LANES-1:0]            neg,
  input  logic [DEN_W-1:0]            den,
  output logic [LANES-1:0][NUM_W-1:0] quo,
  output logic [LANES-1:0]            quo_neg
);

  logic [LANES-1:0][NUM_W-1:0] acc [NUM_W];
  logic [LANES-1:0][DEN_W-1:0] rem [NUM_W];
  logic [LANES-1:0]            sgn [NUM_W];
  logic [DEN_W-1:0]            dv  [NUM_W];

  for (genvar j = 0; j < NUM_W; j++) begin : g_step
    logic [LANES-1:0][NUM_W-1:0] a_in;
    logic [LANES-1:0][DEN_W-1:0] r_in;
    logic [LANES-1:0]            s_in;
    logic [DEN_W-1:0]            d_in;
    logic [LANES-1:0][NUM_W-1:0] a_next;
    logic [LANES-1:0][DEN_W-1:0] r_next;

    if (j == 0) begin : g_first
      assign a_in = num;
      assign r_in = '0;
      assign s_in = neg;
      assign d_in = den;
    end else begin : g_rest
      assign a_in = acc[j-1];
      assign r_in = rem[j-1];
      assign s_in = sgn[j-1];
      assign d_in = dv[j-1];
    end

    always_comb begin
      logic [DEN_W:0] trial;
      for (int l = 0; l < LANES; l++) begin
        trial = {r_in[l], a_in[l][NUM_W-1]};
        if (trial >= {1'b0, d_in}) begin
          r_next[l] = DEN_W'(trial - {1'b0, d_in});
          a_next[l] = {a_in[l][NUM_W-2:0], 1'b1};
        end else begin
          r_next[l] = DEN_W'(trial);
          a_next[l] = {a_in[l][NUM_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[j] <= a_next;
        rem[j] <= r_next;
        sgn[j] <= s_in;
        dv[j]  <= d_in;
      end
    end
  end

  assign quo     = acc[NUM_W-1];
  assign quo_neg = sgn[NUM_W-1];

endmodule

/* rtl/isotropic_collision_scatter.sv */
// Isotropic collision scatter: pair items in, scatter results out through one pipeline.
// Throughput one item per clock, stalled while a result waits and the last stage is full;
// every stage advances together and bubbles squeeze out while a result waits.
// Depth is set by the 33-step square root (CORDIC runs alongside) and the 50-step divider.
// Reset clears the valid bits, holds the input off and sets every species mass to 256;
// datapath and output data registers are not cleared.
module isotropic_collision_scatter import ics_pkg::*; #(
  parameter int NUM_SPECIES = 4,
  parameter int RAND_BITS   = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [MASS_W-1:0]    wr_data,
  ics_pair_if.sink             pair,
  ics_scatter_if.source        scatter
);

  localparam int SEL_W  = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;
  localparam int STAGES = 4 + SQ_STEPS + 4 + DIV_NUM_W + 1;

  // ---------------- configuration ----------------
  logic [MASS_W-1:0] mass [NUM_SPECIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SPECIES; i++) mass[i] <= MASS_RESET;
    end else if (wr_en && (32'(wr_index) < NUM_SPECIES)) begin
      mass[SEL_W'(wr_index)] <= wr_data;
    end
  end

  // ---------------- flow control ----------------
  logic [STAGES-1:0] vld;
  logic              ovld;
  logic              out_take;
  logic              en;

  assign out_take      = !ovld || scatter.ready;
  assign en            = out_take || !vld[STAGES-1];
  assign pair.ready    = en && !rst;
  assign scatter.valid = ovld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      ovld <= 1'b0;
    end else begin
      if (en) vld <= {vld[STAGES-2:0], pair.valid};
      if (out_take) ovld <= vld[STAGES-1];
    end
  end

  // ---------------- stage P0: decode ----------------
  logic [29:0]       r1q;
  logic [31:0]       ang_in;
  logic [SEL_W-1:0]  sel_p;
  logic [SEL_W-1:0]  sel_q;
  logic [MASS_W-1:0] mp_raw;
  logic [MASS_W-1:0] mq_raw;
  side_t             side_in;

  if (RAND_BITS <= 30) begin : g_r1_up
    assign r1q = 30'(pair.rand_theta) << (30 - RAND_BITS);
  end else begin : g_r1_dn
    assign r1q = 30'(pair.rand_theta >> (RAND_BITS - 30));
  end
  assign ang_in = 32'(pair.rand_phi) << (32 - RAND_BITS);

  always_comb begin
    sel_p = (32'(pair.species_p) >= NUM_SPECIES) ? SEL_W'(NUM_SPECIES - 1)
                                                 : SEL_W'(pair.species_p);
    sel_q = (32'(pair.species_q) >= NUM_SPECIES) ? SEL_W'(NUM_SPECIES - 1)
                                                 : SEL_W'(pair.species_q);
    mp_raw = mass[sel_p];
    mq_raw = mass[sel_q];
    side_in.action = pair.action;
    side_in.mp     = (mp_raw == '0) ? MASS_W'(1) : mp_raw;
    side_in.mq     = (mq_raw == '0) ? MASS_W'(1) : mq_raw;
    side_in.up     = {pair.up_z, pair.up_y, pair.up_x};
    side_in.uq     = {pair.uq_z, pair.uq_y, pair.uq_x};
    side_in.crg    = pair.rel_speed;
    // cos(theta) = 2*r1 - 1 in Q30
    side_in.c30    = {r1q, 1'b0} - 31'h4000_0000;
  end

  side_t       p0_side;
  logic [31:0] p0_ang;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_side <= side_in;
      p0_ang  <= ang_in;
    end
  end

  // ---------------- stage P1: velocity differences ----------------
  side_t       p1_side;
  vec3_t       p1_mag;
  logic [31:0] p1_ang;
  vec3_t       mag_next;

  always_comb begin
    logic signed [32:0] df;
    for (int k = 0; k < 3; k++) begin
      df = $signed({p0_side.up[k][31], p0_side.up[k]})
         - $signed({p0_side.uq[k][31], p0_side.uq[k]});
      mag_next[k] = (df < 0) ? 32'(-df) : 32'(df);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_side <= p0_side;
      p1_mag  <= mag_next;
      p1_ang  <= p0_ang;
    end
  end

  // ---------------- stage P2: squares ----------------
  side_t                p2_side;
  logic [63:0]          p2_sq [3];
  logic [SQ_RAD_W-1:0]  p2_rads;
  logic [31:0]          p2_ang;
  logic signed [CQ_W-1:0] c30_p1;
  logic signed [61:0]   csq;
  logic [60:0]          srad;

  assign c30_p1 = $signed(p1_side.c30);
  assign csq    = c30_p1 * c30_p1;
  assign srad   = 61'h1000_0000_0000_0000 - 61'(csq);

  always_ff @(posedge clk) begin
    if (en) begin
      p2_side <= p1_side;
      for (int k = 0; k < 3; k++) p2_sq[k] <= 64'(p1_mag[k]) * 64'(p1_mag[k]);
      // radicand scaled by 16 so both roots share one 33-step schedule
      p2_rads <= SQ_RAD_W'({srad, 4'b0000});
      p2_ang  <= p1_ang;
    end
  end

  // ---------------- stage P3 and Q: square roots and CORDIC ----------------
  sqrt_t   q_sqc  [SQ_STEPS+1];
  sqrt_t   q_sqs  [SQ_STEPS+1];
  cordic_t q_cor  [SQ_STEPS+1];
  logic [1:0] q_quad [SQ_STEPS+1];
  side_t   q_side [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      q_sqc[0].rad  <= 66'(p2_sq[0]) + 66'(p2_sq[1]) + 66'(p2_sq[2]);
      q_sqc[0].rem  <= '0;
      q_sqc[0].root <= '0;
      q_sqs[0].rad  <= p2_rads;
      q_sqs[0].rem  <= '0;
      q_sqs[0].root <= '0;
      q_cor[0].x    <= CORDIC_GAIN;
      q_cor[0].y    <= '0;
      q_cor[0].z    <= $signed({2'b00, p2_ang[29:0]});
      q_quad[0]     <= p2_ang[31:30];
      q_side[0]     <= p2_side;
    end
  end

  for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_q
    always_ff @(posedge clk) begin
      if (en) begin
        q_sqc[j]  <= sqrt_step(q_sqc[j-1]);
        q_sqs[j]  <= sqrt_step(q_sqs[j-1]);
        q_quad[j] <= q_quad[j-1];
        q_side[j] <= q_side[j-1];
      end
    end
    if (j <= CORDIC_STEPS) begin : g_rot
      always_ff @(posedge clk) begin
        if (en) q_cor[j] <= cordic_step(q_cor[j-1], j - 1);
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) q_cor[j] <= q_cor[j-1];
      end
    end
  end

  // ---------------- stage M0: quadrant map, unit vector products ----------------
  side_t              m0_side;
  logic [SQ_ROOT_W-1:0] m0_cr;
  logic signed [63:0] m0_pc;
  logic signed [63:0] m0_ps;
  logic signed [31:0] cph;
  logic signed [31:0] sph;
  logic signed [31:0] s30;
  cordic_t            cend;

  assign cend = q_cor[SQ_STEPS];
  assign s30  = $signed({1'b0, q_sqs[SQ_STEPS].root[SQ_ROOT_W-1:2]});

  always_comb begin
    unique case (q_quad[SQ_STEPS])
      QUAD_0: begin cph = cend.x;  sph = cend.y;  end
      QUAD_1: begin cph = -cend.y; sph = cend.x;  end
      QUAD_2: begin cph = -cend.x; sph = -cend.y; end
      QUAD_3: begin cph = cend.y;  sph = -cend.x; end
      default: begin cph = cend.x; sph = cend.y;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_side <= q_side[SQ_STEPS];
      m0_cr   <= (q_side[SQ_STEPS].action == ACT_DERIVE) ? q_sqc[SQ_STEPS].root
                                                         : SQ_ROOT_W'(q_side[SQ_STEPS].crg);
      m0_pc   <= s30 * cph;
      m0_ps   <= s30 * sph;
    end
  end

  // ---------------- stage M1: g products, centre-of-mass products ----------------
  logic signed [65:0] m1_gp  [3];
  logic signed [49:0] m1_cma [3];
  logic signed [49:0] m1_cmb [3];
  logic [MASS_W-1:0]  m1_mp;
  logic [MASS_W-1:0]  m1_mq;
  logic [DIV_DEN_W-1:0] m1_msum;
  logic signed [31:0] dvec [3];
  logic signed [33:0] cr_s;
  logic [DIV_DEN_W-1:0] msum0;
  logic signed [DIV_DEN_W:0] wa;
  logic signed [DIV_DEN_W:0] wb;

  always_comb begin
    dvec[0] = 32'($signed(m0_side.c30));
    dvec[1] = 32'(m0_pc >>> 30);
    dvec[2] = 32'(m0_ps >>> 30);
    cr_s    = $signed({1'b0, m0_cr});
    msum0   = DIV_DEN_W'(m0_side.mp) + DIV_DEN_W'(m0_side.mq);
    // reaction form: numerator msum*UP returns UP exactly
    if (m0_side.action == ACT_REACT) begin
      wa = $signed({1'b0, msum0});
      wb = '0;
    end else begin
      wa = $signed({2'b00, m0_side.mp});
      wb = $signed({2'b00, m0_side.mq});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m1_gp[k]  <= cr_s * dvec[k];
        m1_cma[k] <= wa * $signed(m0_side.up[k]);
        m1_cmb[k] <= wb * $signed(m0_side.uq[k]);
      end
      m1_mp   <= m0_side.mp;
      m1_mq   <= m0_side.mq;
      m1_msum <= msum0;
    end
  end

  // ---------------- stage M2: mass-fraction numerators ----------------
  logic signed [52:0] m2_tq  [3];
  logic signed [52:0] m2_tp  [3];
  logic signed [50:0] m2_cmn [3];
  logic [DIV_DEN_W-1:0] m2_msum;
  logic signed [35:0] gv [3];

  always_comb begin
    for (int k = 0; k < 3; k++) gv[k] = 36'(m1_gp[k] >>> 30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m2_tq[k]  <= gv[k] * $signed({1'b0, m1_mq});
        m2_tp[k]  <= gv[k] * $signed({1'b0, m1_mp});
        m2_cmn[k] <= 51'(m1_cma[k]) + 51'(m1_cmb[k]);
      end
      m2_msum <= m1_msum;
    end
  end

  // ---------------- stage M3: sign and magnitude ----------------
  logic [DIV_LANES-1:0][DIV_NUM_W-1:0] m3_mag;
  logic [DIV_LANES-1:0]                m3_neg;
  logic [DIV_DEN_W-1:0]                m3_msum;
  logic signed [52:0]                  lane_val [DIV_LANES];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_val[k]     = 53'(m2_cmn[k]);
      lane_val[3 + k] = m2_tq[k];
      lane_val[6 + k] = m2_tp[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        m3_neg[l] <= lane_val[l] < 0;
        m3_mag[l] <= (lane_val[l] < 0) ? DIV_NUM_W'(-lane_val[l]) : DIV_NUM_W'(lane_val[l]);
      end
      m3_msum <= m2_msum;
    end
  end

  // ---------------- stages D: division by the mass sum ----------------
  logic [DIV_LANES-1:0][DIV_NUM_W-1:0] dq_mag;
  logic [DIV_LANES-1:0]                dq_neg;

  ics_div #(
    .LANES (DIV_LANES),
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk     (clk),
    .en      (en),
    .num     (m3_mag),
    .neg     (m3_neg),
    .den     (m3_msum),
    .quo     (dq_mag),
    .quo_neg (dq_neg)
  );

  // ---------------- stage F0: signed quotients ----------------
  logic signed [DIV_NUM_W:0] f0_q [DIV_LANES];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        f0_q[l] <= dq_neg[l] ? -$signed({1'b0, dq_mag[l]}) : $signed({1'b0, dq_mag[l]});
      end
    end
  end

  // ---------------- output register: combine and saturate ----------------
  logic signed [VEL_W-1:0] o_up [3];
  logic signed [VEL_W-1:0] o_uq [3];
  logic                    o_sat;
  logic signed [VEL_W-1:0] up_next [3];
  logic signed [VEL_W-1:0] uq_next [3];
  logic                    sat_next;

  always_comb begin
    logic signed [DIV_NUM_W+1:0] np;
    logic signed [DIV_NUM_W+1:0] nq;
    sat_next = 1'b0;
    for (int k = 0; k < 3; k++) begin
      np = (DIV_NUM_W+2)'(f0_q[k]) + (DIV_NUM_W+2)'(f0_q[3 + k]);
      nq = (DIV_NUM_W+2)'(f0_q[k]) - (DIV_NUM_W+2)'(f0_q[6 + k]);
      if (np > 52'sd2147483647) begin
        up_next[k] = 32'sh7FFF_FFFF;
        sat_next   = 1'b1;
      end else if (np < -52'sd2147483648) begin
        up_next[k] = 32'sh8000_0000;
        sat_next   = 1'b1;
      end else begin
        up_next[k] = VEL_W'(np);
      end
      if (nq > 52'sd2147483647) begin
        uq_next[k] = 32'sh7FFF_FFFF;
        sat_next   = 1'b1;
      end else if (nq < -52'sd2147483648) begin
        uq_next[k] = 32'sh8000_0000;
        sat_next   = 1'b1;
      end else begin
        uq_next[k] = VEL_W'(nq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && vld[STAGES-1]) begin
      o_up  <= up_next;
      o_uq  <= uq_next;
      o_sat <= sat_next;
    end
  end

  assign scatter.new_up_x  = o_up[0];
  assign scatter.new_up_y  = o_up[1];
  assign scatter.new_up_z  = o_up[2];
  assign scatter.new_uq_x  = o_uq[0];
  assign scatter.new_uq_y  = o_uq[1];
  assign scatter.new_uq_z  = o_uq[2];
  assign scatter.saturated = o_sat;

endmodule

/* rtl/ics_chk.sv */
// Port-level checker for the collision scatter, bound to the top level.
module ics_chk import ics_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VEL_W-1:0] new_up_x,
  input logic signed [VEL_W-1:0] new_up_y,
  input logic signed [VEL_W-1:0] new_up_z,
  input logic signed [VEL_W-1:0] new_uq_x,
  input logic signed [VEL_W-1:0] new_uq_y,
  input logic signed [VEL_W-1:0] new_uq_z,
  input logic                    saturated
);

  localparam logic signed [VEL_W-1:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [VEL_W-1:0] VMIN = 32'sh8000_0000;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(new_up_x) && $stable(new_up_y) &&
      $stable(new_up_z) && $stable(new_uq_x) && $stable(new_uq_y) &&
      $stable(new_uq_z) && $stable(saturated))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      new_up_x == VMAX || new_up_x == VMIN || new_up_y == VMAX || new_up_y == VMIN ||
      new_up_z == VMAX || new_up_z == VMIN || new_uq_x == VMAX || new_uq_x == VMIN ||
      new_uq_y == VMAX || new_uq_y == VMIN || new_uq_z == VMAX || new_uq_z == VMIN)
    else $error("saturated flag without a clamped component");

endmodule

bind isotropic_collision_scatter ics_chk u_ics_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pair.ready),
  .out_valid (scatter.valid),
  .out_ready (scatter.ready),
  .new_up_x  (scatter.new_up_x),
  .new_up_y  (scatter.new_up_y),
  .new_up_z  (scatter.new_up_z),
  .new_uq_x  (scatter.new_uq_x),
  .new_uq_y  (scatter.new_uq_y),
  .new_uq_z  (scatter.new_uq_z),
  .saturated (scatter.saturated)
);
